// File: rtl/core/timestamp_nearest_match_cache_unit_defines.svh
// Assertion macros for the timestamp nearest-match cache.
// Used by rtl/core/timestamp_nearest_match_cache_unit.sv; expects clk_i and rst_ni in scope.
`ifndef TIMESTAMP_NEAREST_MATCH_CACHE_UNIT_DEFINES_SVH
`define TIMESTAMP_NEAREST_MATCH_CACHE_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TNMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define TNMC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the following cycle.
`define TNMC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tnmc_pkg.sv
// Package for the timestamp nearest-match cache: widths, constants and types.
// No dependencies; imported by the cache unit, its checker and its testbench.
`timescale 1ns / 1ps

package tnmc_pkg;

  localparam int TS_W        = 48;
  localparam int FPS_W       = 8;
  localparam int CNT_W       = 5;
  localparam int INTERVAL_W  = 10;
  localparam int TOL_W       = 12;
  localparam int AGE_W       = 14;

  localparam int DEF_TABLE_DEPTH  = 16;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam logic [FPS_W-1:0]      FPS_DEFAULT = 8'd30;
  localparam logic [INTERVAL_W-1:0] MS_PER_SEC  = 10'd1000;
  localparam int                    TOL_MULT    = 3;
  localparam int                    AGE_MULT    = 4;
  localparam logic [AGE_W-1:0]      AGE_FLOOR   = 14'd500;
  localparam logic [TOL_W-1:0]      RST_TOL     = 12'd99;
  localparam logic [AGE_W-1:0]      RST_AGE     = 14'd500;

  localparam logic KIND_STORE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_LIMITS,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

// File: rtl/core/timestamp_nearest_match_cache_unit.sv
// Timestamp nearest-match cache: top level with scan sequencer and entry memory.
// Depends on tnmc_pkg and timestamp_nearest_match_cache_unit_defines.svh.
// Channel      | Ports                                             | Direction
// command      | start_i, busy_o, kind_i, timestamp_ms_i, payload_i | in
// result       | done_o, hit_o, matched_timestamp_o,                | out
//              | matched_payload_o, replaced_on_full_o, entry_count_o |
// frame rate   | frame_rate_we_i, frame_rate_i                      | in
//
// A transaction sweeps the entry memory once before the result strobe, one entry per cycle,
// through a three-stage pipe built around the one shared 49-bit subtractor.
// A frame rate write keeps busy_o high while the same subtractor runs a
// restoring division of 1000 by the frame rate, one quotient bit per cycle.
// Reset clears the valid bits and loads the derived limits for 30 frames per second.
// The receiver cannot stall: done_o is high for one cycle only.
`timescale 1ns / 1ps
`include "timestamp_nearest_match_cache_unit_defines.svh"

module timestamp_nearest_match_cache_unit
  import tnmc_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    kind_i,
  input  logic [TS_W-1:0]         timestamp_ms_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [TS_W-1:0]         matched_timestamp_o,
  output logic [PAYLOAD_BITS-1:0] matched_payload_o,
  output logic                    replaced_on_full_o,
  output logic [CNT_W-1:0]        entry_count_o,
  input  logic                    frame_rate_we_i,
  input  logic [FPS_W-1:0]        frame_rate_i
);

  // Index width for the table and width of the occupancy count.
  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int DSW = $clog2(INTERVAL_W);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  state_e state_q, state_d;

  // Configuration and derived limits.
  logic [FPS_W-1:0]      frame_rate_q, frame_rate_d;
  logic [TOL_W-1:0]      tol_q, tol_d;
  logic [AGE_W-1:0]      age_q, age_d;

  // Divider state for 1000 / fps.
  logic [FPS_W-1:0]      div_rem_q, div_rem_d;
  logic [INTERVAL_W-1:0] div_quo_q, div_quo_d;
  logic [DSW-1:0]        div_step_q, div_step_d;
  logic [FPS_W-1:0]      fps_eff;
  logic [FPS_W:0]        rem_shift;
  logic [INTERVAL_W-1:0] interval;
  logic [TOL_W-1:0]      tol_new;
  logic [AGE_W-1:0]      age_raw;

  // The shared subtractor: one borrow bit above the difference.
  logic [TS_W-1:0] sub_a, sub_b;
  logic [TS_W:0]   sub_res;

  // Transaction in flight.
  logic                    kind_q, kind_d;
  logic [TS_W-1:0]         key_q;
  logic [PAYLOAD_BITS-1:0] pay_in_q;

  // Entry storage.
  logic [TABLE_DEPTH-1:0]  ent_valid_q, ent_valid_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [TS_W-1:0]         ts_mem  [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];
  logic [TS_W-1:0]         mem_ts_q;
  logic [PAYLOAD_BITS-1:0] mem_pay_q;
  logic                    mem_we;
  logic [IW-1:0]           slot;

  // Sweep pipeline.
  logic [IW-1:0]           rd_idx_q, rd_idx_d;
  logic                    issue_done_q, issue_done_d;
  logic                    issuing;
  logic                    s1_v_q, s2_v_q, s3_v_q;
  logic [IW-1:0]           s1_idx_q, s2_idx_q, s3_idx_q;
  logic [TS_W:0]           s2_diff_q;
  logic [TS_W-1:0]         s2_ts_q, s3_ts_q, s3_abs_q;
  logic [PAYLOAD_BITS-1:0] s2_pay_q, s3_pay_q;
  logic                    s3_valid, s3_evict;

  // Sweep results: best lookup match or farthest entry for a store.
  logic                    cand_found_q, cand_found_d;
  logic [TS_W-1:0]         cand_d_q, cand_d_d;
  logic [TS_W-1:0]         cand_ts_q, cand_ts_d;
  logic [PAYLOAD_BITS-1:0] cand_pay_q, cand_pay_d;
  logic [IW-1:0]           cand_idx_q, cand_idx_d;
  logic                    match_found_q, match_found_d;
  logic [IW-1:0]           match_idx_q, match_idx_d;
  logic                    free_found_q, free_found_d;
  logic [IW-1:0]           free_idx_q, free_idx_d;
  logic                    cand_better;

  // Result registers.
  logic                    done_q, done_d;
  logic                    hit_q, hit_d;
  logic                    repl_q, repl_d;
  logic [TS_W-1:0]         mts_q, mts_d;
  logic [PAYLOAD_BITS-1:0] mpay_q, mpay_d;

  logic accept;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign issuing = (state_q == ST_SCAN) && !issue_done_q;

  // A frame rate of zero is taken as the default.
  assign fps_eff   = (frame_rate_q == '0) ? FPS_DEFAULT : frame_rate_q;
  assign rem_shift = {div_rem_q, MS_PER_SEC[div_step_q]};

  // The subtractor serves the divider while deriving and the sweep otherwise.
  always_comb begin
    if (state_q == ST_DERIVE) begin
      sub_a = TS_W'(rem_shift);
      sub_b = TS_W'(fps_eff);
    end else begin
      sub_a = key_q;
      sub_b = mem_ts_q;
    end
  end
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

  // Derived limits from the final quotient; narrow values, combinational.
  assign interval = (div_quo_q == '0) ? INTERVAL_W'(1) : div_quo_q;
  assign tol_new  = TOL_W'(interval * TOL_MULT);
  assign age_raw  = AGE_W'(tol_new * AGE_MULT);

  // Decisions for the entry leaving the last pipeline stage.
  assign s3_valid = ent_valid_q[s3_idx_q];
  assign s3_evict = (kind_q == KIND_STORE) && s3_valid && (s3_abs_q > TS_W'(age_q));

  always_comb begin
    if (kind_q == KIND_STORE) begin
      // Farthest entry; a tie goes to the smaller timestamp.
      cand_better = !cand_found_q || (s3_abs_q > cand_d_q) ||
                    ((s3_abs_q == cand_d_q) && (s3_ts_q < cand_ts_q));
    end else begin
      // Nearest entry; a tie goes to the smaller timestamp.
      cand_better = !cand_found_q || (s3_abs_q < cand_d_q) ||
                    ((s3_abs_q == cand_d_q) && (s3_ts_q < cand_ts_q));
    end
  end

  always_comb begin
    state_d       = state_q;
    frame_rate_d  = frame_rate_q;
    tol_d         = tol_q;
    age_d         = age_q;
    div_rem_d     = div_rem_q;
    div_quo_d     = div_quo_q;
    div_step_d    = div_step_q;
    kind_d        = kind_q;
    ent_valid_d   = ent_valid_q;
    cnt_d         = cnt_q;
    rd_idx_d      = rd_idx_q;
    issue_done_d  = issue_done_q;
    cand_found_d  = cand_found_q;
    cand_d_d      = cand_d_q;
    cand_ts_d     = cand_ts_q;
    cand_pay_d    = cand_pay_q;
    cand_idx_d    = cand_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    done_d        = 1'b0;
    hit_d         = hit_q;
    repl_d        = repl_q;
    mts_d         = mts_q;
    mpay_d        = mpay_q;
    mem_we        = 1'b0;
    slot          = cand_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d       = ST_SCAN;
          kind_d        = kind_i;
          rd_idx_d      = '0;
          issue_done_d  = 1'b0;
          cand_found_d  = 1'b0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
        end else if (frame_rate_we_i) begin
          state_d      = ST_DERIVE;
          frame_rate_d = frame_rate_i;
          div_rem_d    = '0;
          div_quo_d    = '0;
          div_step_d   = DSW'(INTERVAL_W - 1);
        end
      end

      ST_DERIVE: begin
        // One restoring division step: keep the remainder if the subtraction borrows.
        if (sub_res[TS_W]) begin
          div_rem_d = rem_shift[FPS_W-1:0];
        end else begin
          div_rem_d = sub_res[FPS_W-1:0];
        end
        div_quo_d = {div_quo_q[INTERVAL_W-2:0], !sub_res[TS_W]};
        if (div_step_q == '0) begin
          state_d = ST_LIMITS;
        end else begin
          div_step_d = div_step_q - DSW'(1);
        end
      end

      ST_LIMITS: begin
        tol_d   = tol_new;
        age_d   = (age_raw < AGE_FLOOR) ? AGE_FLOOR : age_raw;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if (issuing) begin
          if (rd_idx_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
        if (s3_v_q) begin
          if (kind_q == KIND_STORE) begin
            if (s3_evict) begin
              ent_valid_d[s3_idx_q] = 1'b0;
              cnt_d = cnt_q - CW'(1);
            end
            if (s3_valid && !s3_evict) begin
              if (s3_ts_q == key_q) begin
                match_found_d = 1'b1;
                match_idx_d   = s3_idx_q;
              end
              if (cand_better) begin
                cand_found_d = 1'b1;
                cand_d_d     = s3_abs_q;
                cand_ts_d    = s3_ts_q;
                cand_idx_d   = s3_idx_q;
              end
            end else if (!free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = s3_idx_q;
            end
          end else if (s3_valid && (s3_abs_q <= TS_W'(tol_q)) && cand_better) begin
            cand_found_d = 1'b1;
            cand_d_d     = s3_abs_q;
            cand_ts_d    = s3_ts_q;
            cand_pay_d   = s3_pay_q;
            cand_idx_d   = s3_idx_q;
          end
          if (s3_idx_q == LAST_IDX) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (kind_q == KIND_STORE) begin
          hit_d  = 1'b0;
          mts_d  = '0;
          mpay_d = '0;
          repl_d = 1'b0;
          mem_we = 1'b1;
          if (match_found_q) begin
            slot = match_idx_q;
          end else if (free_found_q) begin
            slot  = free_idx_q;
            cnt_d = cnt_q + CW'(1);
          end else begin
            slot   = cand_idx_q;
            repl_d = 1'b1;
          end
          ent_valid_d[slot] = 1'b1;
        end else begin
          repl_d = 1'b0;
          hit_d  = cand_found_q;
          mts_d  = cand_found_q ? cand_ts_q : '0;
          mpay_d = cand_found_q ? cand_pay_q : '0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_rate_q  <= FPS_DEFAULT;
      tol_q         <= RST_TOL;
      age_q         <= RST_AGE;
      div_step_q    <= '0;
      ent_valid_q   <= '0;
      cnt_q         <= '0;
      rd_idx_q      <= '0;
      issue_done_q  <= 1'b1;
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      cand_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      done_q        <= 1'b0;
      kind_q        <= KIND_STORE;
    end else begin
      state_q       <= state_d;
      frame_rate_q  <= frame_rate_d;
      tol_q         <= tol_d;
      age_q         <= age_d;
      div_step_q    <= div_step_d;
      ent_valid_q   <= ent_valid_d;
      cnt_q         <= cnt_d;
      rd_idx_q      <= rd_idx_d;
      issue_done_q  <= issue_done_d;
      s1_v_q        <= issuing;
      s2_v_q        <= s1_v_q;
      s3_v_q        <= s2_v_q;
      cand_found_q  <= cand_found_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      done_q        <= done_d;
      kind_q        <= kind_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= timestamp_ms_i;
      pay_in_q <= payload_i;
    end
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    s1_idx_q   <= rd_idx_q;
    s2_idx_q   <= s1_idx_q;
    s2_diff_q  <= sub_res;
    s2_ts_q    <= mem_ts_q;
    s2_pay_q   <= mem_pay_q;
    s3_idx_q   <= s2_idx_q;
    s3_ts_q    <= s2_ts_q;
    s3_pay_q   <= s2_pay_q;
    s3_abs_q   <= s2_diff_q[TS_W] ? (~s2_diff_q[TS_W-1:0] + TS_W'(1)) : s2_diff_q[TS_W-1:0];
    cand_d_q   <= cand_d_d;
    cand_ts_q  <= cand_ts_d;
    cand_pay_q <= cand_pay_d;
    cand_idx_q <= cand_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q <= free_idx_d;
    hit_q      <= hit_d;
    repl_q     <= repl_d;
    mts_q      <= mts_d;
    mpay_q     <= mpay_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ts_mem[slot]  <= key_q;
      pay_mem[slot] <= pay_in_q;
    end
    mem_ts_q  <= ts_mem[rd_idx_q];
    mem_pay_q <= pay_mem[rd_idx_q];
  end

  assign done_o              = done_q;
  assign hit_o               = hit_q;
  assign matched_timestamp_o = mts_q;
  assign matched_payload_o   = mpay_q;
  assign replaced_on_full_o  = repl_q;
  assign entry_count_o       = CNT_W'(cnt_q);

  `TNMC_ASSERT(a_count_tracks_valid, cnt_q == CW'($countones(ent_valid_q)), "count mismatch")
  `TNMC_ASSERT_IMPL(a_done_after_finish, done_o, $past(state_q == ST_FINISH), "stray strobe")
  `TNMC_ASSERT_NEXT(a_lookup_keeps_table, (state_q == ST_SCAN) && (kind_q == KIND_LOOKUP), $stable(ent_valid_q), "lookup changed table")
  `TNMC_ASSERT_IMPL(a_replace_only_full, done_o && replaced_on_full_o, (cnt_q == CW'(TABLE_DEPTH)) && !hit_o, "replacement with free slot")

endmodule

// File: sim/timestamp_nearest_match_cache_checker.sv
// Result checker for the timestamp nearest-match cache: mirrors the table, predicts each result.
// Depends on tnmc_pkg; instantiated beside the block by tb_timestamp_nearest_match_cache_unit.
`timescale 1ns / 1ps

module timestamp_nearest_match_cache_checker
  import tnmc_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    kind_i,
  input  logic [TS_W-1:0]         timestamp_ms_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic                    done_i,
  input  logic                    hit_i,
  input  logic [TS_W-1:0]         matched_timestamp_i,
  input  logic [PAYLOAD_BITS-1:0] matched_payload_i,
  input  logic                    replaced_on_full_i,
  input  logic [CNT_W-1:0]        entry_count_i,
  input  logic                    frame_rate_we_i,
  input  logic [FPS_W-1:0]        frame_rate_i,
  output int                      error_count_o,
  output int                      pending_count_o,
  output int                      hit_count_o,
  output int                      replaced_count_o
);

  localparam logic [FPS_W-1:0] RESET_FRAME_RATE = 8'd30;
  localparam int               MS_PER_SECOND    = 1000;
  localparam int               WINDOW_FRAMES    = 3;
  localparam int               AGE_WINDOWS      = 4;
  localparam int               MIN_AGE_MS       = 500;

  typedef struct packed {
    logic                    hit;
    logic [TS_W-1:0]         ts;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    replaced;
    logic [CNT_W-1:0]        count;
  } cache_result_t;

  logic                    slot_valid   [TABLE_DEPTH];
  logic [TS_W-1:0]         slot_ts      [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] slot_payload [TABLE_DEPTH];
  logic [TS_W-1:0]         match_window;
  logic [TS_W-1:0]         age_limit;

  cache_result_t expected_results[$];
  int            mismatches;
  int            hits_seen;
  int            replacements_seen;

  function automatic logic [TS_W-1:0] ts_distance(input logic [TS_W-1:0] a,
                                                  input logic [TS_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Tolerance and eviction age follow from the frame rate; 0 counts as the default rate.
  function automatic void derive_limits(input logic [FPS_W-1:0] fps);
    logic [TS_W-1:0] rate;
    logic [TS_W-1:0] interval;
    rate     = (fps == '0) ? TS_W'(RESET_FRAME_RATE) : TS_W'(fps);
    interval = TS_W'(MS_PER_SECOND) / rate;
    if (interval < 1) interval = 1;
    match_window = interval * WINDOW_FRAMES;
    age_limit    = match_window * AGE_WINDOWS;
    if (age_limit < MIN_AGE_MS) age_limit = MIN_AGE_MS;
  endfunction

  function automatic cache_result_t predict_cache_item(input logic                    kind,
                                                       input logic [TS_W-1:0]         ts,
                                                       input logic [PAYLOAD_BITS-1:0] pay);
    cache_result_t   res;
    int              i;
    int              slot;
    int              free_slot;
    int              far_slot;
    int              best_slot;
    int              live;
    logic [TS_W-1:0] d;
    logic [TS_W-1:0] far_d;
    logic [TS_W-1:0] best_d;
    res       = '0;
    slot      = -1;
    free_slot = -1;
    far_slot  = -1;
    best_slot = -1;
    far_d     = '0;
    best_d    = '0;
    if (kind == KIND_STORE) begin
      // Stale entries go first, so they free slots for this very store.
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i] && ts_distance(ts, slot_ts[i]) > age_limit) slot_valid[i] = 1'b0;
      end
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i]) begin
          d = ts_distance(ts, slot_ts[i]);
          if (slot_ts[i] == ts) slot = i;
          if (far_slot < 0 || d > far_d || (d == far_d && slot_ts[i] < slot_ts[far_slot])) begin
            far_slot = i;
            far_d    = d;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot < 0) begin
        if (free_slot >= 0) begin
          slot = free_slot;
        end else begin
          slot         = far_slot;
          res.replaced = 1'b1;
        end
      end
      slot_valid[slot]   = 1'b1;
      slot_ts[slot]      = ts;
      slot_payload[slot] = pay;
    end else begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i]) begin
          d = ts_distance(ts, slot_ts[i]);
          if (d <= match_window &&
              (best_slot < 0 || d < best_d ||
               (d == best_d && slot_ts[i] < slot_ts[best_slot]))) begin
            best_slot = i;
            best_d    = d;
          end
        end
      end
      if (best_slot >= 0) begin
        res.hit     = 1'b1;
        res.ts      = slot_ts[best_slot];
        res.payload = slot_payload[best_slot];
      end
    end
    live = 0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_valid[i]) live++;
    end
    res.count = CNT_W'(live);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    int            i;
    cache_result_t want;
    if (!rst_ni) begin
      for (i = 0; i < TABLE_DEPTH; i++) slot_valid[i] = 1'b0;
      derive_limits(RESET_FRAME_RATE);
      expected_results.delete();
      mismatches        = 0;
      hits_seen         = 0;
      replacements_seen = 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(hit_i));
          check_field("matched_timestamp", 64'(want.ts), 64'(matched_timestamp_i));
          check_field("matched_payload", 64'(want.payload), 64'(matched_payload_i));
          check_field("replaced_on_full", 64'(want.replaced), 64'(replaced_on_full_i));
          check_field("entry_count", 64'(want.count), 64'(entry_count_i));
          if (want.hit) hits_seen++;
          if (want.replaced) replacements_seen++;
        end
      end
      if (frame_rate_we_i) derive_limits(frame_rate_i);
      if (start_i && !busy_i) begin
        expected_results.insert(expected_results.size(),
                                predict_cache_item(kind_i, timestamp_ms_i, payload_i));
      end
    end
    error_count_o    <= mismatches;
    pending_count_o  <= expected_results.size();
    hit_count_o      <= hits_seen;
    replaced_count_o <= replacements_seen;
  end

endmodule

// File: sim/tb_timestamp_nearest_match_cache_unit.sv
// Testbench top for the timestamp nearest-match cache: clock, reset, stimulus and verdict.
// Depends on tnmc_pkg, timestamp_nearest_match_cache_unit and timestamp_nearest_match_cache_checker.
`timescale 1ns / 1ps

module tb_timestamp_nearest_match_cache_unit;
  import tnmc_pkg::*;

  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int PAYLOAD_BITS = DEF_PAYLOAD_BITS;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 140;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    start_i         = 1'b0;
  logic                    kind_i          = KIND_STORE;
  logic [TS_W-1:0]         timestamp_ms_i  = '0;
  logic [PAYLOAD_BITS-1:0] payload_i       = '0;
  logic                    frame_rate_we_i = 1'b0;
  logic [FPS_W-1:0]        frame_rate_i    = 8'd30;
  logic                    busy_o;
  logic                    done_o;
  logic                    hit_o;
  logic [TS_W-1:0]         matched_timestamp_o;
  logic [PAYLOAD_BITS-1:0] matched_payload_o;
  logic                    replaced_on_full_o;
  logic [CNT_W-1:0]        entry_count_o;

  int checker_errors;
  int pending_results;
  int lookups_hit;
  int full_replacements;

  // Transactions left in the current burst before the sender drops start and idles.
  int burst_left     = 0;
  int stores_sent    = 0;
  int lookups_sent   = 0;
  int rates_exercised = 1;

  always #5 clk_i = ~clk_i;

  timestamp_nearest_match_cache_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .timestamp_ms_i     (timestamp_ms_i),
    .payload_i          (payload_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .matched_timestamp_o(matched_timestamp_o),
    .matched_payload_o  (matched_payload_o),
    .replaced_on_full_o (replaced_on_full_o),
    .entry_count_o      (entry_count_o),
    .frame_rate_we_i    (frame_rate_we_i),
    .frame_rate_i       (frame_rate_i)
  );

  // The checker sees exactly what the block sees and keeps its own copy of the table.
  timestamp_nearest_match_cache_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_result_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_i             (busy_o),
    .kind_i             (kind_i),
    .timestamp_ms_i     (timestamp_ms_i),
    .payload_i          (payload_i),
    .done_i             (done_o),
    .hit_i              (hit_o),
    .matched_timestamp_i(matched_timestamp_o),
    .matched_payload_i  (matched_payload_o),
    .replaced_on_full_i (replaced_on_full_o),
    .entry_count_i      (entry_count_o),
    .frame_rate_we_i    (frame_rate_we_i),
    .frame_rate_i       (frame_rate_i),
    .error_count_o      (checker_errors),
    .pending_count_o    (pending_results),
    .hit_count_o        (lookups_hit),
    .replaced_count_o   (full_replacements)
  );

  // Offers one transaction and returns at the edge that accepts it. It must be called at a
  // rising edge. Within a burst start stays high, so the next transaction is offered with no
  // gap; at the end of a burst start is dropped and the sender idles for a random spell, long
  // enough at times to outlast a whole sweep of the table.
  task automatic send_transaction(input logic                    kind,
                                  input logic [TS_W-1:0]         ts,
                                  input logic [PAYLOAD_BITS-1:0] pay);
    start_i        <= 1'b1;
    kind_i         <= kind;
    timestamp_ms_i <= ts;
    payload_i      <= pay;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (kind == KIND_STORE) stores_sent++;
    else lookups_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      // Mostly short bursts, now and then a long stretch with no idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4);
    end
  endtask

  // Holds the sender off until every outstanding result has come back and the block is idle.
  // The first edge is always waited for, so a transaction accepted at this very edge counts.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0 || busy_o);
    burst_left = 0;
  endtask

  // The frame rate is only changed with the table idle. The write is a single cycle pulse;
  // the block raises busy while it works out the new limits, which the sender then waits on.
  task automatic write_frame_rate(input logic [FPS_W-1:0] rate);
    drain_results();
    frame_rate_we_i <= 1'b1;
    frame_rate_i    <= rate;
    @(posedge clk_i);
    frame_rate_we_i <= 1'b0;
    rates_exercised++;
  endtask

  // Directed sequence at the reset frame rate: tolerance 99 ms, eviction age 500 ms.
  task automatic run_directed();
    int k;
    send_transaction(KIND_LOOKUP, 48'd1000, '0);           // empty table misses
    send_transaction(KIND_STORE, 48'd1000, '1);
    send_transaction(KIND_STORE, 48'd1000, 32'h1234_5678); // same key is overwritten
    send_transaction(KIND_LOOKUP, 48'd1099, '1);           // on the tolerance edge, payload ignored
    send_transaction(KIND_LOOKUP, 48'd1100, '0);           // one past the tolerance
    send_transaction(KIND_STORE, 48'd1050, '0);
    send_transaction(KIND_LOOKUP, 48'd1025, '0);           // equal distance, smaller key wins
    send_transaction(KIND_STORE, 48'd1500, 32'hA5A5_5A5A); // age exactly at the limit survives
    send_transaction(KIND_STORE, 48'd1501, 32'h0F0F_F0F0); // oldest evicted, its slot reused
    for (k = 2; k <= 14; k++) begin
      send_transaction(KIND_STORE, TS_W'(1500 + k), PAYLOAD_BITS'($urandom));
    end
    // The table is now full; 1050 and 1514 are equally far from 1282, so 1050 goes.
    send_transaction(KIND_STORE, 48'd1282, 32'hDEAD_BEEF);
    send_transaction(KIND_STORE, '1, '0);                  // far in the future, clears the rest
    send_transaction(KIND_LOOKUP, '1, '1);
    send_transaction(KIND_LOOKUP, '0, '0);
  endtask

  // Random traffic shaped like a video stream: results are stored near a running clock that
  // advances by fractions of a frame, so the table fills and ages naturally, while lookups land
  // around recently stored keys within a little more than the tolerance. A small share of
  // full-range timestamps, the extremes and sudden jumps keep every bit and mass eviction busy.
  task automatic run_random_phase(input logic [FPS_W-1:0] rate, input int n_items);
    logic [TS_W-1:0] now_ms;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] lookup_base;
    logic [TS_W-1:0] recent_keys [8];
    logic            kind;
    int              frame_ms;
    int              window;
    int              roll;
    int              k;
    frame_ms = 1000 / ((rate == '0) ? 30 : int'(rate));
    window   = 3 * frame_ms;
    case ($urandom_range(0, 2))
      0:       now_ms = TS_W'($urandom_range(0, 1000));
      1:       now_ms = '1 - TS_W'($urandom_range(0, 20000));
      default: now_ms = TS_W'({$urandom, $urandom});
    endcase
    for (k = 0; k < 8; k++) recent_keys[k] = now_ms;
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        kind = 1'($urandom);
        ts   = TS_W'({$urandom, $urandom});
      end else if (roll < 7) begin
        kind = 1'($urandom);
        ts   = (roll == 5) ? '0 : '1;
      end else if (roll < 8) begin
        now_ms = now_ms + TS_W'(20 * window + 600);
        kind   = KIND_STORE;
        ts     = now_ms;
      end else begin
        now_ms = now_ms + TS_W'($urandom_range(0, frame_ms / 4 + 1));
        if ($urandom_range(0, 99) < 55) begin
          kind = KIND_STORE;
          ts   = ($urandom_range(0, 6) == 0) ? recent_keys[$urandom_range(0, 7)] : now_ms;
          recent_keys[$urandom_range(0, 7)] = ts;
        end else begin
          kind        = KIND_LOOKUP;
          lookup_base = ($urandom_range(0, 2) == 0) ? now_ms : recent_keys[$urandom_range(0, 7)];
          ts = lookup_base + TS_W'(longint'($urandom_range(0, 2 * window + 4)) -
                                   longint'(window + 2));
        end
      end
      send_transaction(kind, ts, PAYLOAD_BITS'($urandom));
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  initial begin
    logic [FPS_W-1:0] phase_rates [PHASES];
    int               p;
    // Both ends of the frame rate, the slowest real rate, the default written explicitly,
    // and two arbitrary rates in between.
    phase_rates[0] = 8'd0;
    phase_rates[1] = 8'd255;
    phase_rates[2] = 8'd1;
    phase_rates[3] = FPS_W'($urandom_range(2, 254));
    phase_rates[4] = 8'd30;
    phase_rates[5] = FPS_W'($urandom_range(2, 254));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      write_frame_rate(phase_rates[p]);
      run_random_phase(phase_rates[p], PHASE_ITEMS);
    end
    drain_results();
    // Room for any stray strobe after the last expected result.
    repeat (30) @(posedge clk_i);
    $display("Ran %0d stores and %0d lookups under %0d frame-rate settings.",
             stores_sent, lookups_sent, rates_exercised);
    $display("%0d lookups found a match and %0d stores displaced an entry of a full table.",
             lookups_hit, full_replacements);
    if (checker_errors == 0 && pending_results == 0) begin
      $display("timestamp_nearest_match_cache_unit verification clean");
    end else begin
      $display("timestamp_nearest_match_cache_unit verification failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a millisecond of simulated time.
  initial begin
    #5_000_000;
    $display("timestamp_nearest_match_cache_unit verification failed");
    $finish;
  end

endmodule
